// ----- design/mexp_pkg.sv -----
// ----------------------------------------------------------------------------
// mexp_pkg: shared types and constants of the modular exponentiation block
// Word widths, controller states and the command and status groups that run
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package mexp_pkg;

  // Width of the arithmetic datapath; operands are truncated to it.
  localparam int WORD_BITS  = 64;
  // Width of the base, exponent, modulus and power ports.
  localparam int FIELD_BITS = 64;
  // Step counter width: counts WORD_BITS steps of one bit-serial pass.
  localparam int CNT_BITS   = $clog2(WORD_BITS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_NEXTBIT,
    ST_MUL_ACC,
    ST_MUL_SQ,
    ST_FINISH
  } mexp_state_e;

  typedef struct packed {
    logic load;      // capture a new request, result starts at one
    logic div_step;  // one restoring step of the base reduction
    logic mul_load;  // clear the product and load the square as multiplier
    logic mul_step;  // one double-and-add step of the modular multiply
    logic sel_sq;    // multiplicand is the square rather than the result
    logic sq_wr;     // write the finished value into the square register
    logic acc_wr;    // write the finished product into the result register
    logic e_shift;   // drop the lowest exponent bit
    logic out_load;  // copy the result into the output register
  } mexp_cmd_t;

  typedef struct packed {
    logic cnt_zero;  // last step of the current bit-serial pass
    logic e_zero;    // no exponent bits left
    logic e_lsb;     // lowest remaining exponent bit
  } mexp_status_t;

endpackage

// ----- design/modular_exponentiation_top.sv -----
// ----------------------------------------------------------------------------
// modular_exponentiation_top: base^exponent mod modulus, right to left
// Throughput: one request at a time; the shared bit-serial multiply unit
//   works one bit per cycle. A new request is taken while the previous
//   result waits in the output register.
// Reset: modulus returns to 1, the sequencer idles and no result is pending.
// ----------------------------------------------------------------------------
module modular_exponentiation_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration: the modulus register.
  input  logic                            cfg_we_i,
  input  logic [mexp_pkg::FIELD_BITS-1:0] cfg_wdata_i,
  // Request channel.
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [mexp_pkg::FIELD_BITS-1:0] base_i,
  input  logic [mexp_pkg::FIELD_BITS-1:0] exponent_i,
  // Result channel.
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [mexp_pkg::FIELD_BITS-1:0] power_o
);

  // The controller sequences the work and the datapath does it; they talk
  // only through the command and status groups below.
  mexp_pkg::mexp_cmd_t    cmd;
  mexp_pkg::mexp_status_t status;

  // The controller first reduces the base modulo the modulus with a
  // restoring remainder pass of one bit per cycle. It then walks the
  // exponent from its lowest bit: a set bit multiplies the running result
  // by the running square, and every bit squares the running square. Each
  // multiply is a double-and-add pass over the multiplier bits, one bit per
  // cycle, keeping the partial product reduced. The walk ends as soon as
  // no exponent bits remain, so a zero exponent returns the initial 1.
  mexp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // The datapath holds the modulus register. A modulus of zero makes all
  // arithmetic wrap at the word width. The finished power sits in an
  // output register of its own, so the request side can be freed before
  // the result is taken.
  mexp_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .base_i      (base_i),
    .exponent_i  (exponent_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .power_o     (power_o)
  );

endmodule

// ----- design/mexp_datapath.sv -----
// ----------------------------------------------------------------------------
// mexp_datapath: registers and bit-serial arithmetic of modular exponentiation
// Holds the modulus, the running result, the running square and the exponent,
// and a shared unit that does one reduction or one multiply step per cycle.
// ----------------------------------------------------------------------------
module mexp_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mexp_pkg::FIELD_BITS-1:0]     cfg_wdata_i,
  input  logic [mexp_pkg::FIELD_BITS-1:0]     base_i,
  input  logic [mexp_pkg::FIELD_BITS-1:0]     exponent_i,
  input  mexp_pkg::mexp_cmd_t                 cmd_i,
  output mexp_pkg::mexp_status_t              status_o,
  output logic [mexp_pkg::FIELD_BITS-1:0]     power_o
);

  localparam int W  = mexp_pkg::WORD_BITS;
  localparam int CB = mexp_pkg::CNT_BITS;

  logic [W-1:0]  m_q;
  logic [W-1:0]  r_q;
  logic [W-1:0]  b_q;
  logic [W-1:0]  acc_q;
  logic [W-1:0]  sq_q;
  logic [W-1:0]  e_q;
  logic [W-1:0]  power_q;
  logic [CB-1:0] cnt_q;

  logic          m_zero;
  logic [W:0]    div_t;
  logic [W-1:0]  div_next;
  logic [W-1:0]  mul_a;
  logic [W+1:0]  mul_t;
  logic [W+1:0]  m1;
  logic [W+1:0]  m2;
  logic [W-1:0]  mul_next;

  // A zero modulus stands for 2^W: nothing is ever subtracted and the
  // arithmetic wraps at the word width.
  assign m_zero = (m_q == '0);

  // Restoring remainder step, base bits enter MSB first.
  always_comb begin
    div_t = {r_q, b_q[W-1]};
    if (!m_zero && (div_t >= {1'b0, m_q})) begin
      div_next = W'(div_t - {1'b0, m_q});
    end else begin
      div_next = W'(div_t);
    end
  end

  // Double-and-add step. With the product below m and the multiplicand at
  // most m, the sum stays below 3m and one of three candidates is reduced.
  assign mul_a = cmd_i.sel_sq ? sq_q : acc_q;
  assign m1    = {2'b00, m_q};
  assign m2    = {1'b0, m_q, 1'b0};

  always_comb begin
    mul_t = {1'b0, r_q, 1'b0} + (b_q[W-1] ? {2'b00, mul_a} : '0);
    if (m_zero) begin
      mul_next = mul_t[W-1:0];
    end else if (mul_t >= m2) begin
      mul_next = W'(mul_t - m2);
    end else if (mul_t >= m1) begin
      mul_next = W'(mul_t - m1);
    end else begin
      mul_next = mul_t[W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_q   <= W'(1);
      cnt_q <= '0;
    end else begin
      if (cfg_we_i) begin
        m_q <= W'(cfg_wdata_i);
      end
      if (cmd_i.load || cmd_i.mul_load) begin
        cnt_q <= CB'(W - 1);
      end else if (cmd_i.div_step || cmd_i.mul_step) begin
        cnt_q <= cnt_q - CB'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      r_q   <= '0;
      b_q   <= W'(base_i);
      e_q   <= W'(exponent_i);
      acc_q <= W'(1);
    end else begin
      if (cmd_i.div_step) begin
        r_q <= div_next;
        b_q <= b_q << 1;
      end else if (cmd_i.mul_load) begin
        r_q <= '0;
        b_q <= sq_q;
      end else if (cmd_i.mul_step) begin
        r_q <= mul_next;
        b_q <= b_q << 1;
      end
      if (cmd_i.acc_wr) begin
        acc_q <= mul_next;
      end
      if (cmd_i.e_shift) begin
        e_q <= e_q >> 1;
      end
    end
    if (cmd_i.sq_wr) begin
      sq_q <= cmd_i.div_step ? div_next : mul_next;
    end
    if (cmd_i.out_load) begin
      power_q <= acc_q;
    end
  end

  assign status_o.cnt_zero = (cnt_q == '0);
  assign status_o.e_zero   = (e_q == '0);
  assign status_o.e_lsb    = e_q[0];

  assign power_o = mexp_pkg::FIELD_BITS'(power_q);

  // The partial product stays reduced throughout a multiply.
  a_prod_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.mul_step && !cmd_i.mul_load && !m_zero) |-> (r_q < m_q))
    else $error("partial product not reduced below the modulus");

  // Every value written to the square register is reduced, unless the modulus is zero or being rewritten.
  a_sq_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.sq_wr && !m_zero && !cfg_we_i) |=> (sq_q < m_q))
    else $error("square register not reduced below the modulus");

endmodule

// ----- design/mexp_ctrl.sv -----
// ----------------------------------------------------------------------------
// mexp_ctrl: sequencer of the modular exponentiation block
// Walks the exponent bits, issues reduction and multiply passes to the
// datapath and owns the request handshakes on both channels.
// ----------------------------------------------------------------------------
module mexp_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  input  mexp_pkg::mexp_status_t status_i,
  output mexp_pkg::mexp_cmd_t    cmd_o
);

  mexp_pkg::mexp_state_e state_q, state_d;
  logic                  out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mexp_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      mexp_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = mexp_pkg::ST_REDUCE;
        end
      end
      mexp_pkg::ST_REDUCE: begin
        cmd_o.div_step = 1'b1;
        if (status_i.cnt_zero) begin
          cmd_o.sq_wr = 1'b1;
          state_d     = mexp_pkg::ST_NEXTBIT;
        end
      end
      mexp_pkg::ST_NEXTBIT: begin
        if (status_i.e_zero) begin
          state_d = mexp_pkg::ST_FINISH;
        end else begin
          cmd_o.mul_load = 1'b1;
          state_d = status_i.e_lsb ? mexp_pkg::ST_MUL_ACC : mexp_pkg::ST_MUL_SQ;
        end
      end
      mexp_pkg::ST_MUL_ACC: begin
        cmd_o.mul_step = 1'b1;
        if (status_i.cnt_zero) begin
          cmd_o.acc_wr   = 1'b1;
          cmd_o.mul_load = 1'b1;
          state_d        = mexp_pkg::ST_MUL_SQ;
        end
      end
      mexp_pkg::ST_MUL_SQ: begin
        cmd_o.mul_step = 1'b1;
        cmd_o.sel_sq   = 1'b1;
        if (status_i.cnt_zero) begin
          cmd_o.sq_wr   = 1'b1;
          cmd_o.e_shift = 1'b1;
          state_d       = mexp_pkg::ST_NEXTBIT;
        end
      end
      mexp_pkg::ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = mexp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mexp_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  // An accepted request always starts with the base reduction.
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == mexp_pkg::ST_REDUCE))
    else $error("accepted request did not start the reduction");

  // A finished result waits while the pending one is still stalled.
  a_finish_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mexp_pkg::ST_FINISH && out_valid_q && out_stall_i)
      |=> (state_q == mexp_pkg::ST_FINISH && out_valid_q))
    else $error("pending result overwritten");

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for modular_exponentiation_top
// Requests of base and exponent are sent through the valid/stall channel and
// each power that comes back is compared with an independent computation of
// base^exponent mod modulus made at full width. The modulus register is
// rewritten between phases once the block has drained. Directed corner cases
// come first, then random requests under several moduli, with random idle
// bursts on both channels except in the last phase.
// ----------------------------------------------------------------------------
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = mexp_pkg::FIELD_BITS;
  localparam logic [W-1:0] ALL_ONES = '1;
  // Largest prime below 2^64 and a modulus just above 2^32.
  localparam logic [W-1:0] BIG_PRIME  = 64'hFFFF_FFFF_FFFF_FFC5;
  localparam logic [W-1:0] WIDE_MOD   = 64'h0000_0001_0000_000F;

  // Every input of the block starts at a known value.
  logic         clk_i       = 1'b0;
  logic         rst_ni      = 1'b0;
  logic         cfg_we_i    = 1'b0;
  logic [W-1:0] cfg_wdata_i = '0;
  logic         in_valid_i  = 1'b0;
  logic         in_stall_o;
  logic [W-1:0] base_i      = '0;
  logic [W-1:0] exponent_i  = '0;
  logic         out_valid_o;
  logic         out_stall_i = 1'b0;
  logic [W-1:0] power_o;

  // Our copy of the modulus register; it resets to one like the block.
  logic [W-1:0] modulus_q = 64'd1;
  // Powers that accepted requests will produce, oldest first.
  logic [W-1:0] power_expected[$];
  int           mismatches = 0;
  // When set, neither side inserts idle cycles.
  bit           quiet = 1'b0;
  int           stall_run = 0;

  modular_exponentiation_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .base_i      (base_i),
    .exponent_i  (exponent_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .power_o     (power_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // (a * b) mod m with the product kept at double width; a modulus of zero
  // stands for 2^W, so the product simply wraps at the word width.
  function automatic logic [W-1:0] mul_mod_wide(logic [W-1:0] a, logic [W-1:0] b,
                                                logic [W-1:0] m);
    logic [2*W-1:0] prod;
    prod = {{W{1'b0}}, a} * {{W{1'b0}}, b};
    if (m == '0) begin
      return prod[W-1:0];
    end
    return W'(prod % {{W{1'b0}}, m});
  endfunction

  // Right-to-left square and multiply. The base is reduced first, while the
  // running result starts at one and is only ever touched by a multiply, so
  // a zero exponent gives one even when the modulus is one.
  function automatic logic [W-1:0] predict_power(logic [W-1:0] b, logic [W-1:0] e,
                                                 logic [W-1:0] m);
    logic [W-1:0] sq;
    logic [W-1:0] acc;
    logic [W-1:0] bits_left;
    sq = b;
    acc = 64'd1;
    bits_left = e;
    if (m != '0) begin
      sq = b % m;
    end
    while (bits_left != '0) begin
      if (bits_left[0]) begin
        acc = mul_mod_wide(acc, sq, m);
      end
      sq = mul_mod_wide(sq, sq, m);
      bits_left = bits_left >> 1;
    end
    return acc;
  endfunction

  // Result side: check each accepted power against the oldest expectation,
  // then decide whether to hold off the next result. Both signals are
  // sampled at the edge, before this process updates the stall.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (power_expected.size() == 0) begin
        $error("power: result %h arrived with no request outstanding", power_o);
        mismatches++;
      end else if (power_o !== power_expected[0]) begin
        $error("power mismatch: expected %h, actual %h", power_expected[0], power_o);
        mismatches++;
        void'(power_expected.pop_front());
      end else begin
        void'(power_expected.pop_front());
      end
    end
    // Stall in bursts of random length, leaving long clear stretches too.
    if (stall_run == 0 && !quiet && $urandom_range(0, 7) == 0) begin
      stall_run = $urandom_range(1, 6);
    end
    out_stall_i <= (stall_run != 0) && !quiet;
    if (stall_run != 0) begin
      stall_run--;
    end
  end

  // Present one request and hold it until the block takes it. Valid is left
  // high afterwards so that back-to-back requests never lower and raise it in
  // the same step; a gap, a register write or the end of the run lowers it.
  task automatic send_request(input logic [W-1:0] b, input logic [W-1:0] e);
    if (!quiet && $urandom_range(0, 2) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    base_i     <= b;
    exponent_i <= e;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    power_expected.push_back(predict_power(b, e, modulus_q));
  endtask

  // The modulus is only rewritten once every outstanding power has come
  // back, which also makes the sender pause until the block has drained.
  task automatic set_modulus(input logic [W-1:0] value);
    in_valid_i <= 1'b0;
    while (power_expected.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    modulus_q = value;
  endtask

  // The reset value of the modulus is one: every power is zero except for a
  // zero exponent, which still gives one.
  task automatic test_reset_modulus();
    send_request(64'd5, 64'd0);
    send_request(64'd5, 64'd3);
    send_request(64'd0, 64'd0);
    send_request(ALL_ONES, ALL_ONES);
  endtask

  // Field extremes under the largest prime and the all-ones modulus.
  task automatic test_extremes();
    set_modulus(BIG_PRIME);
    send_request(ALL_ONES, ALL_ONES);
    send_request(64'd0, 64'd5);
    send_request(64'd0, 64'd0);
    send_request(64'd1, ALL_ONES);
    send_request(64'd2, 64'd64);
    send_request(ALL_ONES, 64'd1);
    send_request(64'd3, 64'h8000_0000_0000_0000);
    send_request(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    send_request(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
    set_modulus(ALL_ONES);
    send_request(ALL_ONES, 64'd2);
    send_request(ALL_ONES - 64'd1, 64'd3);
  endtask

  // A zero modulus stands for 2^64: all arithmetic wraps at the word width.
  task automatic test_zero_modulus();
    set_modulus(64'd0);
    send_request(64'd3, 64'hFFFF);
    send_request(ALL_ONES, ALL_ONES);
    send_request(64'd2, 64'd64);
    send_request(64'd2, 64'd63);
    send_request(64'd7, 64'd0);
  endtask

  // A modulus above 2^32 needs the products at full width.
  task automatic test_wide_modulus();
    set_modulus(WIDE_MOD);
    send_request(ALL_ONES, ALL_ONES);
    send_request({$urandom, $urandom}, {$urandom, $urandom});
    send_request(WIDE_MOD - 64'd1, 64'd2);
  endtask

  // Random requests in phases, each under its own modulus. Half of the
  // exponents use all 64 bits; the rest are short so the run stays brief.
  // The last phase runs with no idling on either side.
  task automatic test_random();
    logic [W-1:0] b;
    logic [W-1:0] e;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0:       set_modulus({$urandom, $urandom});
        1:       set_modulus(64'($urandom_range(1, 1000)));
        2:       set_modulus({32'd0, $urandom} | 64'd1);
        3:       set_modulus({32'($urandom_range(1, 32'h7FFF_FFFF)), $urandom});
        default: set_modulus({$urandom, $urandom});
      endcase
      quiet = (phase == 4);
      for (int n = 0; n < 16; n++) begin
        e = {$urandom, $urandom};
        if ($urandom_range(0, 1) == 0) begin
          e = e & ((64'd1 << $urandom_range(0, 16)) - 64'd1);
        end
        case ($urandom_range(0, 7))
          0:       b = '0;
          1:       b = ALL_ONES;
          2:       b = modulus_q - 64'd1;
          default: b = {$urandom, $urandom};
        endcase
        send_request(b, e);
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_modulus();
    test_extremes();
    test_zero_modulus();
    test_wide_modulus();
    test_random();
    in_valid_i <= 1'b0;
    // Every request yields exactly one power, so the block is idle as soon
    // as the last one is back; a short tail catches any extra result.
    while (power_expected.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // A timeout at several times the length of the slowest correct run.
  initial begin
    #50_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

// ----- modular_exponentiation_top.f -----
design/mexp_pkg.sv
design/mexp_datapath.sv
design/mexp_ctrl.sv
design/modular_exponentiation_top.sv
tb/testbench.sv
